### design/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg: shared types and constants of the text console glyph renderer
// Item structs for the input and result channels, register indexes and
// character and command codes.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // cell geometry
  localparam int unsigned GlyphRows = 16;
  localparam int unsigned CellWidth = 8;
  localparam int unsigned RowW      = 4;

  // field widths
  localparam int unsigned XW       = 13;
  localparam int unsigned YW       = 12;
  localparam int unsigned PitchW   = 14;
  localparam int unsigned StrideW  = 5;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned IndexW   = 25;
  localparam int unsigned GaddrW   = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PITCH        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FG_COLOR     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLEAR_COLOR  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_STRIDE = 3'd4;

  // commands and control characters
  localparam logic       CMD_RENDER     = 1'b0;
  localparam logic       CMD_LOAD       = 1'b1;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;

  // register reset values
  localparam logic [PitchW-1:0]  PITCH_RESET  = 14'd1024;
  localparam logic [PitchW-1:0]  SWIDTH_RESET = 14'd1024;
  localparam logic [ColorW-1:0]  FG_RESET     = 32'hFFFF_FFFF;
  localparam logic [ColorW-1:0]  CLEAR_RESET  = 32'h0000_0000;
  localparam logic [StrideW-1:0] STRIDE_RESET = 5'd16;
  localparam logic [YW-1:0]      Y_MAX        = 12'd4095;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic [11:0] font_index;
    logic [7:0] font_byte;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] pixel_index;
    logic [7:0]        pixel_mask;
    logic [ColorW-1:0] color;
    logic              last_row;
  } out_item_t;

endpackage

### design/text_console_glyph_renderer_core.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core: 8x16 text console glyph renderer
// Draws characters at a text cursor as masked row writes into a framebuffer,
// with a font held in an on-chip glyph RAM loaded byte by byte.
// ----------------------------------------------------------------------------
// A render or backspace item is taken while the block is idle; the sequencer
// then steps through the sixteen glyph rows. A render reads each row from the
// single read port of the glyph RAM; a backspace reads nothing and writes each
// row with the clear color. Each row result passes through the RAM read
// register and then the output register, and a new item is taken in the
// cycle right after the sixteenth row is issued. Font loads, newlines and
// backspaces at column 0 give no result. The glyph RAM is not cleared
// after reset; load a font before rendering from it. Output stall holds the
// read pipeline in place with nothing lost. Configuration writes are always
// ready and must only come while the block is idle.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core #(
  parameter int unsigned FONT_BYTES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tcgr_pkg::in_item_t            in_item_i,
  // row writes
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tcgr_pkg::out_item_t           out_item_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcgr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tcgr_pkg::CfgDataW-1:0] cfg_data_i
);
  import tcgr_pkg::*;

  localparam int unsigned AW = $clog2(FONT_BYTES);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // configuration registers
  logic [PitchW-1:0]  pitch_q, swidth_q;
  logic [ColorW-1:0]  fg_q, clr_q;
  logic [StrideW-1:0] stride_q;

  // cursor and sequencer
  logic [XW-1:0]      cur_x_q, cur_x_d;
  logic [YW-1:0]      cur_y_q, cur_y_d;
  logic               state_q, state_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [IndexW-1:0]  idx_q, idx_d;
  logic [GaddrW-1:0]  base_q, base_d;
  logic               erase_q, erase_d;

  // read stage (row whose glyph byte sits in the RAM read register)
  logic               s1_valid_q, s1_valid_d;
  logic [IndexW-1:0]  s1_idx_q;
  logic               s1_last_q, s1_erase_q;

  // output register
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q;

  logic               in_acc, out_free, issue, s1_move;
  logic               is_bs, is_nl;
  logic [XW-1:0]      x_eff;
  logic [25:0]        prod;
  logic [XW:0]        nx;
  logic [XW+1:0]      nx_end;
  logic [YW:0]        ny;
  logic [YW-1:0]      y_nl;
  logic [GaddrW-1:0]  raw_addr;
  logic [GaddrW:0]    mod_addr;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr, ram_waddr;
  logic [7:0]         ram_rdata;

  assign cfg_ready_o = 1'b1;

  // ---- configuration port ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q  <= PITCH_RESET;
      swidth_q <= SWIDTH_RESET;
      fg_q     <= FG_RESET;
      clr_q    <= CLEAR_RESET;
      stride_q <= STRIDE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PITCH:        pitch_q  <= cfg_data_i[PitchW-1:0];
        CFG_SCREEN_WIDTH: swidth_q <= cfg_data_i[PitchW-1:0];
        CFG_FG_COLOR:     fg_q     <= cfg_data_i[ColorW-1:0];
        CFG_CLEAR_COLOR:  clr_q    <= cfg_data_i[ColorW-1:0];
        CFG_GLYPH_STRIDE: stride_q <= cfg_data_i[StrideW-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---- handshake ----
  assign in_stall_o = (state_q == ST_RUN);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  // a row read may go out when the read register is free or moves on now
  assign issue      = (state_q == ST_RUN) && (!s1_valid_q || out_free);
  assign s1_move    = s1_valid_q && out_free;

  // ---- item decode ----
  assign is_nl = (in_item_i.command == CMD_RENDER) && (in_item_i.char_code == CHAR_NEWLINE);
  assign is_bs = (in_item_i.command == CMD_RENDER) && (in_item_i.char_code == CHAR_BACKSPACE);

  // backspace draws the cell it steps back onto
  assign x_eff = is_bs ? (cur_x_q - XW'(CellWidth)) : cur_x_q;
  // start index of the cell: x + y * pitch, wrapped to the index width
  assign prod  = 26'(cur_y_q) * 26'(pitch_q);

  // cursor step for a printed character, with wrap check
  assign nx     = {1'b0, cur_x_q} + (XW+1)'(CellWidth);
  assign nx_end = {1'b0, nx} + (XW+2)'(CellWidth);
  assign ny     = {1'b0, cur_y_q} + (YW+1)'(GlyphRows);
  assign y_nl   = ny[YW] ? Y_MAX : ny[YW-1:0];

  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    idx_d    = idx_q;
    base_d   = base_q;
    erase_d  = erase_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_item_i.command == CMD_RENDER)) begin
          if (is_nl) begin
            cur_x_d = '0;
            cur_y_d = y_nl;
          end else if (is_bs) begin
            // nothing to erase at column 0
            if (cur_x_q >= XW'(CellWidth)) begin
              cur_x_d = x_eff;
              state_d = ST_RUN;
              erase_d = 1'b1;
              row_d   = '0;
              idx_d   = prod[IndexW-1:0] + IndexW'(x_eff);
            end
          end else begin
            state_d = ST_RUN;
            erase_d = 1'b0;
            row_d   = '0;
            idx_d   = prod[IndexW-1:0] + IndexW'(x_eff);
            base_d  = GaddrW'(in_item_i.char_code) * GaddrW'(stride_q);
            if (nx[XW] || (nx_end > (XW+2)'(swidth_q))) begin
              cur_x_d = '0;
              cur_y_d = y_nl;
            end else begin
              cur_x_d = nx[XW-1:0];
            end
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          row_d = row_q + RowW'(1);
          idx_d = idx_q + IndexW'(pitch_q);
          if (row_q == RowW'(GlyphRows - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      erase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      erase_q <= erase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    base_q <= base_d;
  end

  // ---- glyph RAM ----
  // row address wraps once at most: code * stride + row stays below 2 * depth
  assign raw_addr  = base_q + GaddrW'(row_q);
  assign mod_addr  = ({1'b0, raw_addr} >= (GaddrW+1)'(FONT_BYTES))
                   ? ({1'b0, raw_addr} - (GaddrW+1)'(FONT_BYTES))
                   : {1'b0, raw_addr};
  assign ram_raddr = mod_addr[AW-1:0];
  assign ram_re    = issue && !erase_q;
  assign ram_we    = in_acc && (in_item_i.command == CMD_LOAD);
  assign ram_waddr = AW'(in_item_i.font_index);

  tcgr_ram #(
    .Width (8),
    .Depth (FONT_BYTES)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_item_i.font_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---- read stage ----
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (issue) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q   <= idx_q;
      s1_last_q  <= (row_q == RowW'(GlyphRows - 1));
      s1_erase_q <= erase_q;
    end
  end

  // ---- output register ----
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.pixel_index <= s1_idx_q;
      out_q.pixel_mask  <= s1_erase_q ? 8'hFF : ram_rdata;
      out_q.color       <= s1_erase_q ? clr_q : fg_q;
      out_q.last_row    <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---- assertions ----
  // a row waiting behind a stalled output is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> s1_valid_q)
    else $error("read stage lost a row under output stall");

  // the sixteenth row issue ends the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (row_q == RowW'(GlyphRows - 1))) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after last row");

  // row counter is parked at zero between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (row_q == '0))
    else $error("row counter not cleared in idle");

  // font loads and glyph reads never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("glyph RAM read and write in the same cycle");

endmodule

### design/tcgr_ram.sv
// ----------------------------------------------------------------------------
// tcgr_ram: generic single-clock RAM
// One write port and one read port, read data registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module tcgr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sim/text_console_glyph_renderer_core_test.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core_test: self-checking bench for the renderer
// Loads glyphs into the font RAM, walks a short table of hand-picked
// characters, then drives random traffic through several screen setups while
// a behavioral copy of the renderer predicts every row write.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcgr_pkg::*;

  localparam int unsigned FontBytes    = 4096;
  localparam int unsigned XLimit       = (1 << XW) - 1;
  // register slots past the last defined one, written to show they are ignored
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  localparam int SettleCycles = 8;     // a no-result item may still be in flight
  localparam int LongHold     = 400;   // receiver hold-off to back up the block
  localparam int DrainLimit   = 20000;
  localparam int MaxShown     = 10;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_WALK, FILL_WALK_INV} glyph_fill_e;

  // one directed row: the item, and where the first row write is obvious,
  // that write typed in by hand
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t row0;
  } probe_t;

  localparam out_item_t NoRow = '0;

  // glyph 0 holds a walking one (row 0 = 80), glyph 255 its inverse (row 0 = 7f)
  // reset setup: pitch 1024, width 1024, fg all ones, clear zero
  localparam probe_t Probes [19] = '{
    // backspace at column 0 does nothing
    '{'{CMD_RENDER, CHAR_BACKSPACE, 12'h000, 8'h00}, 1'b0, NoRow},
    // first cell after reset, junk in the font fields
    '{'{CMD_RENDER, 8'd0, 12'hFFF, 8'hFF}, 1'b1, '{25'd0, 8'h80, 32'hFFFF_FFFF, 1'b0}},
    '{'{CMD_RENDER, 8'd255, 12'h000, 8'h00}, 1'b1, '{25'd8, 8'h7F, 32'hFFFF_FFFF, 1'b0}},
    // erase both cells again
    '{'{CMD_RENDER, CHAR_BACKSPACE, 12'h000, 8'h00}, 1'b1, '{25'd8, 8'hFF, 32'h0, 1'b0}},
    '{'{CMD_RENDER, CHAR_BACKSPACE, 12'h000, 8'h00}, 1'b1, '{25'd0, 8'hFF, 32'h0, 1'b0}},
    '{'{CMD_RENDER, CHAR_BACKSPACE, 12'h000, 8'h00}, 1'b0, NoRow},
    '{'{CMD_RENDER, CHAR_NEWLINE, 12'h000, 8'h00}, 1'b0, NoRow},
    '{'{CMD_RENDER, 8'd0, 12'h000, 8'h00}, 1'b1, '{25'd16384, 8'h80, 32'hFFFF_FFFF, 1'b0}},
    // font bytes at both ends of the store, and loads carrying control codes
    '{'{CMD_LOAD, 8'd0, 12'h000, 8'h00}, 1'b0, NoRow},
    '{'{CMD_LOAD, 8'hFF, 12'hFFF, 8'hFF}, 1'b0, NoRow},
    '{'{CMD_LOAD, CHAR_NEWLINE, 12'hFF0, 8'h00}, 1'b0, NoRow},
    '{'{CMD_RENDER, 8'd0, 12'h000, 8'h00}, 1'b0, NoRow},
    '{'{CMD_RENDER, 8'd255, 12'h000, 8'h00}, 1'b0, NoRow},
    '{'{CMD_RENDER, CHAR_NEWLINE, 12'h000, 8'h00}, 1'b0, NoRow},
    '{'{CMD_RENDER, CHAR_NEWLINE, 12'h000, 8'h00}, 1'b0, NoRow},
    '{'{CMD_RENDER, 8'd255, 12'h000, 8'h00}, 1'b1, '{25'd49152, 8'h00, 32'hFFFF_FFFF, 1'b0}},
    '{'{CMD_RENDER, CHAR_BACKSPACE, 12'h000, 8'h00}, 1'b1, '{25'd49152, 8'hFF, 32'h0, 1'b0}},
    '{'{CMD_LOAD, CHAR_BACKSPACE, 12'h0F0, 8'hA5}, 1'b0, NoRow},
    '{'{CMD_RENDER, 8'd0, 12'h000, 8'h00}, 1'b0, NoRow}
  };

  // dut connections, all inputs known from time zero
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // predicted renderer state
  logic [PitchW-1:0]  pitch_q  = PITCH_RESET;
  logic [PitchW-1:0]  swidth_q = SWIDTH_RESET;
  logic [ColorW-1:0]  fg_q     = FG_RESET;
  logic [ColorW-1:0]  clr_q    = CLEAR_RESET;
  logic [StrideW-1:0] stride_q = STRIDE_RESET;
  int unsigned        cur_x    = 0;
  int unsigned        cur_y    = 0;
  logic [7:0]         font_mem [FontBytes];
  bit                 font_set [FontBytes];

  out_item_t  row_writes_due [$];   // predicted row writes, oldest first
  logic [7:0] ready_codes [$];      // glyphs whose sixteen rows are all loaded

  int fails      = 0;
  int shown      = 0;
  int items_sent = 0;
  bit quiet_run  = 1'b0;            // no idling on either side
  bit hold_out   = 1'b0;            // request for one long receiver hold-off

  text_console_glyph_renderer_core #(
    .FONT_BYTES (FontBytes)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // renderer prediction
  // --------------------------------------------------------------------------

  // cursor to start of next text line, y pinned at the bottom
  function automatic void next_line();
    cur_x = 0;
    cur_y = (cur_y + GlyphRows > Y_MAX) ? Y_MAX : cur_y + GlyphRows;
  endfunction

  // sixteen row writes of the cell under the cursor, glyph or erase
  function automatic void push_cell(input bit erase, input logic [7:0] code);
    longint unsigned span;
    int unsigned     addr;
    out_item_t       w;
    for (int r = 0; r < GlyphRows; r++) begin
      // pixel index wraps at 25 bits
      span          = longint'(cur_x) + (longint'(cur_y) + r) * longint'(pitch_q);
      addr          = (code * stride_q + r) % FontBytes;
      w.pixel_index = span[IndexW-1:0];
      w.pixel_mask  = erase ? 8'hFF : font_mem[addr];
      w.color       = erase ? clr_q : fg_q;
      w.last_row    = (r == GlyphRows - 1);
      row_writes_due.push_back(w);
    end
  endfunction

  function automatic void predict_item(input in_item_t it);
    int unsigned nx;
    if (it.command == CMD_LOAD) begin
      font_mem[it.font_index % FontBytes] = it.font_byte;
      font_set[it.font_index % FontBytes] = 1'b1;
    end else if (it.char_code == CHAR_NEWLINE) begin
      next_line();
    end else if (it.char_code == CHAR_BACKSPACE) begin
      // at column 0 there is nothing to erase
      if (cur_x >= CellWidth) begin
        cur_x = cur_x - CellWidth;
        push_cell(1'b1, it.char_code);
      end
    end else begin
      push_cell(1'b0, it.char_code);
      // wrap when the next cell would not fit or x leaves its 13 bits
      nx = cur_x + CellWidth;
      if (nx > XLimit || nx + CellWidth > swidth_q) next_line();
      else cur_x = nx;
    end
  endfunction

  function automatic bit glyph_ready(input logic [7:0] code);
    for (int r = 0; r < GlyphRows; r++)
      if (!font_set[(code * stride_q + r) % FontBytes]) return 1'b0;
    return 1'b1;
  endfunction

  // random printable glyph, falling back to one known to be loaded
  function automatic logic [7:0] pick_glyph();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == CHAR_NEWLINE || c == CHAR_BACKSPACE || !glyph_ready(c))
      c = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    return c;
  endfunction

  // font byte with extra weight on empty and full rows
  function automatic logic [7:0] font_row();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // drivers, all entered and left just after a falling edge
  // --------------------------------------------------------------------------

  // one input transfer, with an occasional idle burst ahead of it
  task automatic send_item(input in_item_t it);
    if (!quiet_run && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // stop offering, let every predicted row write arrive, then a few quiet cycles
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (row_writes_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PITCH:        pitch_q  = data[PitchW-1:0];
      CFG_SCREEN_WIDTH: swidth_q = data[PitchW-1:0];
      CFG_FG_COLOR:     fg_q     = data[ColorW-1:0];
      CFG_CLEAR_COLOR:  clr_q    = data[ColorW-1:0];
      CFG_GLYPH_STRIDE: stride_q = data[StrideW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // new screen setup, only once the block has gone idle
  task automatic set_mode(input logic [PitchW-1:0] pitch, input logic [PitchW-1:0] width,
                          input logic [ColorW-1:0] fg, input logic [ColorW-1:0] clr);
    wait_idle();
    write_reg(CFG_PITCH, CfgDataW'(pitch));
    write_reg(CFG_SCREEN_WIDTH, CfgDataW'(width));
    write_reg(CFG_FG_COLOR, fg);
    write_reg(CFG_CLEAR_COLOR, clr);
    write_reg(CFG_GLYPH_STRIDE, CfgDataW'(STRIDE_RESET));
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    cfg_valid_i = 1'b0;
  endtask

  // font load of the first rows of one glyph; a full glyph becomes renderable
  task automatic load_glyph(input logic [7:0] code, input glyph_fill_e fill, input int rows);
    in_item_t   it;
    logic [7:0] walk;
    for (int r = 0; r < rows; r++) begin
      walk          = (r < 8) ? (8'h80 >> r) : (8'h01 << (r - 8));
      it.command    = CMD_LOAD;
      it.char_code  = 8'($urandom);
      it.font_index = 12'((code * stride_q + r) % FontBytes);
      case (fill)
        FILL_WALK:     it.font_byte = walk;
        FILL_WALK_INV: it.font_byte = ~walk;
        default:       it.font_byte = font_row();
      endcase
      send_item(it);
    end
    if (rows == GlyphRows && code != CHAR_NEWLINE && code != CHAR_BACKSPACE)
      ready_codes.push_back(code);
  endtask

  // random traffic; feed_heavy keeps to characters, newlines and rare
  // backspaces so the cursor marches down the screen quickly
  task automatic run_phase(input int count, input bit feed_heavy);
    int       stop;
    int       roll;
    in_item_t it;
    stop = items_sent + count;
    while (items_sent < stop) begin
      roll          = $urandom_range(0, 99);
      it.command    = CMD_RENDER;
      it.char_code  = pick_glyph();
      it.font_index = 12'($urandom);
      it.font_byte  = 8'($urandom);
      if (feed_heavy) begin
        if (roll >= 95) it.char_code = CHAR_BACKSPACE;
        else if (roll >= 55) it.char_code = CHAR_NEWLINE;
        send_item(it);
      end else if (roll < 55) begin
        send_item(it);
      end else if (roll < 70) begin
        it.char_code = CHAR_BACKSPACE;
        send_item(it);
      end else if (roll < 78) begin
        it.char_code = CHAR_NEWLINE;
        send_item(it);
      end else if (roll < 81) begin
        load_glyph(8'($urandom), FILL_RANDOM, GlyphRows);
      end else if (roll < 91) begin
        // stray font byte anywhere in the store
        it.command   = CMD_LOAD;
        it.font_byte = font_row();
        send_item(it);
      end else begin
        // glyph load abandoned part way, never rendered from
        load_glyph(8'($urandom), FILL_RANDOM, $urandom_range(1, GlyphRows - 1));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : row_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i = 1'b1;
      end else if (hold_out) begin
        hold_out    = 1'b0;
        stall_left  = LongHold - 1;
        out_stall_i = 1'b1;
      end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
        stall_left  = $urandom_range(0, 16);
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // row write checker, compares each transfer with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : row_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (row_writes_due.size() == 0) begin
        fails++;
        if (shown < MaxShown) begin
          shown++;
          $display("unexpected row write: index %0d mask %02h color %08h last %0b",
                   out_item_o.pixel_index, out_item_o.pixel_mask, out_item_o.color,
                   out_item_o.last_row);
        end
      end else begin
        want = row_writes_due.pop_front();
        if (out_item_o.pixel_index !== want.pixel_index ||
            out_item_o.pixel_mask  !== want.pixel_mask  ||
            out_item_o.color       !== want.color       ||
            out_item_o.last_row    !== want.last_row) begin
          fails++;
          if (shown < MaxShown) begin
            shown++;
            $display("row write mismatch at %0t: want index %0d mask %02h color %08h last %0b",
                     $realtime, want.pixel_index, want.pixel_mask, want.color, want.last_row);
            $display("                          got  index %0d mask %02h color %08h last %0b",
                     out_item_o.pixel_index, out_item_o.pixel_mask, out_item_o.color,
                     out_item_o.last_row);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int spins;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // font RAM is not cleared, so glyphs are loaded before any is drawn;
    // glyph 0 and glyph 255 between them touch both ends of the store
    load_glyph(8'd0, FILL_WALK, GlyphRows);
    load_glyph(8'd255, FILL_WALK_INV, GlyphRows);

    // directed table at the reset setup
    for (int k = 0; k < $size(Probes); k++) begin
      send_item(Probes[k].item);
      // the item's sixteen writes are the newest predictions, none sent yet
      if (Probes[k].typed)
        row_writes_due[row_writes_due.size() - GlyphRows] = Probes[k].row0;
    end

    // narrow screens wrap often; sender drains in the middle
    set_mode(PitchW'($urandom_range(1, 2048)), PitchW'($urandom_range(16, 256)),
             $urandom, $urandom);
    run_phase(20, 1'b0);
    wait_idle();
    run_phase(20, 1'b0);

    // widest setup; receiver holds off long enough to back up the input
    set_mode(14'd8192, 14'd8192, 32'h0000_0000, 32'hFFFF_FFFF);
    hold_out = 1'b1;
    run_phase(30, 1'b0);

    // one cell per line: y climbs to its limit and the index wraps at 2^25
    set_mode(14'd8192, 14'd8, $urandom, $urandom);
    run_phase(280, 1'b1);

    // last stretch without idling on either side
    set_mode(14'd1, 14'd8192, 32'hFFFF_FFFF, 32'h0000_0000);
    quiet_run = 1'b1;
    run_phase(30, 1'b0);

    // drain with a bound, anything left over is a failure
    in_valid_i = 1'b0;
    spins = 0;
    while (row_writes_due.size() != 0 && spins < DrainLimit) begin
      @(negedge clk_i);
      spins++;
    end
    repeat (SettleCycles) @(negedge clk_i);
    if (row_writes_due.size() != 0) begin
      fails += row_writes_due.size();
      if (shown < MaxShown) $display("%0d row writes never arrived", row_writes_due.size());
    end

    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // about 430 items with stalls and gaps come to ~3 ms at worst;
  // allow five times that
  initial begin : watchdog
    #15ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
design/tcgr_pkg.sv
design/tcgr_ram.sv
design/text_console_glyph_renderer_core.sv
sim/text_console_glyph_renderer_core_test.sv
